### hw/rtl/dsi_pkg.sv
// dsi_pkg: widths, fixed-point constants, register codes and shared helpers
// for the double slit intensity pipeline. No dependencies.
`timescale 1ns / 1ps

package dsi_pkg;

	localparam int POS_W  = 24;
	localparam int OUT_W  = 17;
	localparam int WID_W  = 14;
	localparam int SEP_W  = 15;
	localparam int LAM_W  = 14;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// lane position carries the detector offset at full width
	localparam int YL_W   = POS_W + 1;
	localparam int AY_W   = POS_W;
	localparam int SQ_W   = 2 * AY_W + 1;
	localparam int ROOT_W = (SQ_W + 1) / 2;
	localparam int VAL_W  = 2 * ROOT_W;
	localparam int S_W    = 30;
	localparam int LEN_W  = SEP_W;
	localparam int PROD_W = LEN_W + S_W;
	localparam int Q30_W  = 31;
	localparam int LO_W   = 15;
	localparam int DH_W   = PROD_W - LO_W + Q30_W;
	localparam int DEN_W  = DH_W - 14;
	localparam int SMALL_SH = 18;

	localparam int LANE_LAT = 2 + ROOT_W + S_W + 1 + PROD_W + 8 + Q30_W + 2;
	localparam int PIPE_LAT = LANE_LAT + 2;

	localparam logic [Q30_W-1:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [Q30_W-1:0] Q30_HALF = 31'h2000_0000;
	localparam logic [Q30_W-1:0] SIN_C1   = 31'd1686629713;
	localparam logic [Q30_W-1:0] SIN_C3   = 31'd693598668;
	localparam logic [Q30_W-1:0] SIN_C5   = 31'd85569306;
	localparam logic [Q30_W-1:0] SIN_C7   = 31'd5026995;
	localparam logic [Q30_W-1:0] SIN_C9   = 31'd172272;
	localparam logic [Q30_W-1:0] PI_Q29   = 31'd1686629713;
	localparam logic [Q30_W-1:0] RND_HALF = 31'd8192;
	localparam logic [SQ_W-1:0]  DIST_SQ  = 49'h64_0000_0000;
	localparam logic [OUT_W-1:0] OUT_MAX  = 17'd65536;

	localparam logic [WID_W-1:0] WIDTH_RST = 14'd3277;
	localparam logic [SEP_W-1:0] SEP_RST   = 15'd8192;
	localparam logic [LAM_W-1:0] LAM_RST   = 14'd4096;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_SEP    = 2'd1,
		REG_LAMBDA = 2'd2,
		REG_MODE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [LAM_W-1:0] lam;
		logic             is_sinc;
	} lane_cfg_t;

	// q30 product, floored; callers keep the result below 2^31
	function automatic logic [Q30_W-1:0] q30_mul(input logic [Q30_W-1:0] a,
		input logic [Q30_W-1:0] b);
		logic [2*Q30_W-1:0] p;
		p = a * b;
		return p[2*Q30_W-2:Q30_W-1];
	endfunction

endpackage

### hw/rtl/dsi_sqrt_cell.sv
// dsi_sqrt_cell: one registered digit step of the integer square root chain.
// Standalone cell, no package needed.
`timescale 1ns / 1ps

module dsi_sqrt_cell #(
	parameter int RW = 25
) (
	input  logic          clk,
	input  logic          en,
	input  logic [RW+1:0] rem_i,
	input  logic [RW-1:0] root_i,
	input  logic [2*RW-1:0] val_i,
	output logic [RW+1:0] rem_o,
	output logic [RW-1:0] root_o,
	output logic [2*RW-1:0] val_o
);

	logic [RW+3:0] sh;
	logic [RW+3:0] trial;
	logic [RW+3:0] diff;
	logic          ge;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [2*RW-1:0] val_q;

	always_comb begin
		sh    = {rem_i, val_i[2*RW-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		ge    = sh >= trial;
		diff  = sh - trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[RW+1:0] : sh[RW+1:0];
			root_q <= {root_i[RW-2:0], ge};
			val_q  <= {val_i[2*RW-3:0], 2'b00};
		end
	end

	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign val_o  = val_q;

endmodule

### hw/rtl/dsi_div_cell.sv
// dsi_div_cell: one registered restoring-division step, one quotient bit.
// Standalone cell, no package needed.
`timescale 1ns / 1ps

module dsi_div_cell #(
	parameter int NW = 30,
	parameter int DW = 25
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_i,
	input  logic [NW-1:0] nq_i,
	input  logic [DW-1:0] den_i,
	output logic [DW-1:0] rem_o,
	output logic [NW-1:0] nq_o,
	output logic [DW-1:0] den_o
);

	logic [DW:0]   sh;
	logic [DW:0]   diff;
	logic          ge;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] nq_q;

	// numerator bits shift out the top, quotient bits shift in below
	always_comb begin
		sh   = {rem_i, nq_i[NW-1]};
		diff = sh - {1'b0, den_i};
		ge   = sh >= {1'b0, den_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
			nq_q  <= {nq_i[NW-2:0], ge};
			den_q <= den_i;
		end
	end

	assign rem_o = rem_q;
	assign nq_o  = nq_q;
	assign den_o = den_q;

endmodule

### hw/rtl/dsi_lane.sv
// dsi_lane: one envelope lane, position to sin(theta), phase, |sin| and
// sinc or cos, squared. Uses dsi_pkg, dsi_sqrt_cell and dsi_div_cell.
`timescale 1ns / 1ps

module dsi_lane (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [dsi_pkg::YL_W-1:0] y,
	input  dsi_pkg::lane_cfg_t             cfg,
	output logic [dsi_pkg::Q30_W-1:0]      env
);
	import dsi_pkg::*;

	// stage numbers count the stages outside the cell chains
	logic [YL_W-1:0]   y_mag;
	logic [AY_W-1:0]   ay_s1;
	logic [AY_W-1:0]   ay_s2;
	logic [2*AY_W-1:0] ay_sq;
	logic [SQ_W-1:0]   sq_s2;
	logic [AY_W-1:0]   ay_d_q [ROOT_W];

	logic [ROOT_W+1:0] sr_rem  [ROOT_W+1];
	logic [ROOT_W-1:0] sr_root [ROOT_W+1];
	logic [VAL_W-1:0]  sr_val  [ROOT_W+1];

	logic [ROOT_W-1:0] sd_rem [S_W+1];
	logic [S_W-1:0]    sd_nq  [S_W+1];
	logic [ROOT_W-1:0] sd_den [S_W+1];

	logic [PROD_W-1:0] prod_c;
	logic [PROD_W-1:0] prod_s3;

	logic [LAM_W-1:0]  hd_rem [PROD_W+1];
	logic [PROD_W-1:0] hd_nq  [PROD_W+1];
	logic [LAM_W-1:0]  hd_den [PROD_W+1];

	logic [PROD_W-1:0] u;
	logic [S_W-1:0]    p;
	logic [Q30_W-1:0]  p_w;
	logic [Q30_W-1:0]  q_m;
	logic [2*Q30_W-1:0] dl_full;
	logic [DH_W-1:0]   dh_c;
	logic [DH_W-1:0]   den_sum;

	logic [Q30_W-1:0]  x_s4, x_s5, x_s6, x_s7, x_s8, x_s9;
	logic              small_s4, small_s5, small_s6, small_s7, small_s8, small_s9;
	logic              small_s10;
	logic [DH_W-1:0]   dh_s4;
	logic [Q30_W-1:0]  dl_s4;
	logic [DEN_W-1:0]  den_s5, den_s6, den_s7, den_s8, den_s9, den_s10;
	logic [Q30_W-1:0]  z_s5, z_s6, z_s7, z_s8;
	logic [Q30_W-1:0]  a7_s6, a5_s7, a3_s8, a1_s9;
	logic [Q30_W-1:0]  r_c;
	logic [Q30_W-1:0]  sn_s10;

	logic [Q30_W-1:0]  nsn;
	logic [DEN_W-1:0]  dden;
	logic [DEN_W-1:0]  sc_rem [Q30_W+1];
	logic [Q30_W-1:0]  sc_nq  [Q30_W+1];
	logic [DEN_W-1:0]  sc_den [Q30_W+1];
	logic [DEN_W-1:0]  sc_rem_s11;
	logic [Q30_W-1:0]  sc_nq_s11;
	logic [DEN_W-1:0]  sc_den_s11;
	logic              sat_s11;
	logic [Q30_W-1:0]  sat_d_q;
	logic [Q30_W-1:0]  qt;
	logic [Q30_W-1:0]  sc_s12;
	logic [Q30_W-1:0]  env_s13;

	// |y| and y^2 + L^2
	assign y_mag = y[YL_W-1] ? YL_W'(-y) : YL_W'(y);
	assign ay_sq = ay_s1 * ay_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ay_s1 <= y_mag[AY_W-1:0];
			ay_s2 <= ay_s1;
			sq_s2 <= {1'b0, ay_sq} + DIST_SQ;
			ay_d_q[0] <= ay_s2;
			for (int i = 1; i < ROOT_W; i++) begin
				ay_d_q[i] <= ay_d_q[i-1];
			end
		end
	end

	// square root chain, two radicand bits per cell
	assign sr_rem[0]  = '0;
	assign sr_root[0] = '0;
	assign sr_val[0]  = VAL_W'(sq_s2);

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		dsi_sqrt_cell #(.RW(ROOT_W)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (sr_rem[k]),
			.root_i (sr_root[k]),
			.val_i  (sr_val[k]),
			.rem_o  (sr_rem[k+1]),
			.root_o (sr_root[k+1]),
			.val_o  (sr_val[k+1])
		);
	end

	// sin(theta) = |y| * 2^30 / root, |y| < root so the upper bits are skipped
	assign sd_rem[0] = ROOT_W'(ay_d_q[ROOT_W-1]);
	assign sd_nq[0]  = '0;
	assign sd_den[0] = sr_root[ROOT_W];

	for (genvar k = 0; k < S_W; k++) begin : g_sdiv
		dsi_div_cell #(.NW(S_W), .DW(ROOT_W)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (sd_rem[k]),
			.nq_i  (sd_nq[k]),
			.den_i (sd_den[k]),
			.rem_o (sd_rem[k+1]),
			.nq_o  (sd_nq[k+1]),
			.den_o (sd_den[k+1])
		);
	end

	assign prod_c = cfg.len * sd_nq[S_W];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_c;
		end
	end

	// phase in half-turns = len * s / lambda
	assign hd_rem[0] = '0;
	assign hd_nq[0]  = prod_s3;
	assign hd_den[0] = cfg.lam;

	for (genvar k = 0; k < PROD_W; k++) begin : g_hdiv
		dsi_div_cell #(.NW(PROD_W), .DW(LAM_W)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (hd_rem[k]),
			.nq_i  (hd_nq[k]),
			.den_i (hd_den[k]),
			.rem_o (hd_rem[k+1]),
			.nq_o  (hd_nq[k+1]),
			.den_o (hd_den[k+1])
		);
	end

	assign u = hd_nq[PROD_W];

	// cos lane adds a quarter turn, then fold the phase into [0, 1/2]
	always_comb begin
		p       = u[S_W-1:0] + (cfg.is_sinc ? '0 : Q30_HALF[S_W-1:0]);
		p_w     = {1'b0, p};
		q_m     = (p_w > Q30_HALF) ? (Q30_ONE - p_w) : p_w;
		dh_c    = u[PROD_W-1:LO_W] * PI_Q29;
		dl_full = Q30_W'(u[LO_W-1:0]) * PI_Q29;
		den_sum = dh_s4 + DH_W'(dl_s4);
		r_c     = q30_mul(x_s9, a1_s9);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s4     <= {q_m[S_W-1:0], 1'b0};
			small_s4 <= (u[PROD_W-1:SMALL_SH] == '0);
			dh_s4    <= dh_c;
			dl_s4    <= dl_full[LO_W+Q30_W-1:LO_W];

			x_s5     <= x_s4;
			small_s5 <= small_s4;
			z_s5     <= q30_mul(x_s4, x_s4);
			den_s5   <= den_sum[DH_W-1:DH_W-DEN_W];

			x_s6     <= x_s5;
			small_s6 <= small_s5;
			z_s6     <= z_s5;
			den_s6   <= den_s5;
			a7_s6    <= SIN_C7 - q30_mul(SIN_C9, z_s5);

			x_s7     <= x_s6;
			small_s7 <= small_s6;
			z_s7     <= z_s6;
			den_s7   <= den_s6;
			a5_s7    <= SIN_C5 - q30_mul(a7_s6, z_s6);

			x_s8     <= x_s7;
			small_s8 <= small_s7;
			z_s8     <= z_s7;
			den_s8   <= den_s7;
			a3_s8    <= SIN_C3 - q30_mul(a5_s7, z_s7);

			x_s9     <= x_s8;
			small_s9 <= small_s8;
			den_s9   <= den_s8;
			a1_s9    <= SIN_C1 - q30_mul(a3_s8, z_s8);

			sn_s10    <= (r_c > Q30_ONE) ? Q30_ONE : r_c;
			small_s10 <= small_s9;
			den_s10   <= den_s9;
		end
	end

	// cos lane divides by one, tiny phase gives one over one
	always_comb begin
		if (!cfg.is_sinc) begin
			nsn  = sn_s10;
			dden = DEN_W'(Q30_ONE);
		end else if (small_s10) begin
			nsn  = Q30_ONE;
			dden = DEN_W'(Q30_ONE);
		end else begin
			nsn  = sn_s10;
			dden = den_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_rem_s11 <= DEN_W'(nsn[Q30_W-1:1]);
			sc_nq_s11  <= {nsn[0], (Q30_W-1)'(0)};
			sc_den_s11 <= dden;
			sat_s11    <= DEN_W'(nsn[Q30_W-1:1]) >= dden;
			sat_d_q    <= {sat_d_q[Q30_W-2:0], sat_s11};
		end
	end

	assign sc_rem[0] = sc_rem_s11;
	assign sc_nq[0]  = sc_nq_s11;
	assign sc_den[0] = sc_den_s11;

	for (genvar k = 0; k < Q30_W; k++) begin : g_cdiv
		dsi_div_cell #(.NW(Q30_W), .DW(DEN_W)) u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (sc_rem[k]),
			.nq_i  (sc_nq[k]),
			.den_i (sc_den[k]),
			.rem_o (sc_rem[k+1]),
			.nq_o  (sc_nq[k+1]),
			.den_o (sc_den[k+1])
		);
	end

	assign qt = sc_nq[Q30_W];

	always_ff @(posedge clk) begin
		if (en) begin
			sc_s12  <= (sat_d_q[Q30_W-1] || qt > Q30_ONE) ? Q30_ONE : qt;
			env_s13 <= q30_mul(sc_s12, sc_s12);
		end
	end

	assign env = env_s13;

endmodule

### hw/rtl/double_slit_intensity.sv
// double_slit_intensity: top level, register port, two envelope lanes,
// combine stage and output skid buffer. Uses dsi_pkg and dsi_lane.
// accepts one beat per cycle while the skid register is empty; the square root
// and divider chains are pipelined, one bit per cell
// the whole pipeline stalls only while the skid register is full
// reset clears valid state and loads register defaults, no clearing pass
`timescale 1ns / 1ps

module double_slit_intensity (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [dsi_pkg::POS_W-1:0]  screen_pos,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dsi_pkg::OUT_W-1:0]         intensity,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [dsi_pkg::ADDR_W-1:0]        paddr,
	input  logic [dsi_pkg::DATA_W-1:0]        pwdata,
	output logic [dsi_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import dsi_pkg::*;

	logic [WID_W-1:0] width_q;
	logic [SEP_W-1:0] sep_q;
	logic [LAM_W-1:0] lam_q;
	logic             mode_q;
	logic             cfg_wr;
	reg_idx_t         reg_idx;

	logic             en;
	logic [PIPE_LAT-1:0] vld_q;
	logic signed [POS_W-1:0] y_s1;
	logic signed [YL_W-1:0]  ys;
	logic signed [YL_W-1:0]  hs;
	logic signed [YL_W-1:0]  ya;
	logic signed [YL_W-1:0]  yb;
	logic [LAM_W-1:0] lam_eff;
	lane_cfg_t        cfg_a;
	lane_cfg_t        cfg_b;
	logic [Q30_W-1:0] env_a;
	logic [Q30_W-1:0] env_b;
	logic [Q30_W:0]   env_sum;
	logic [Q30_W-1:0] val_s2;
	logic [Q30_W-1:0] rnd;
	logic [OUT_W-1:0] res;
	logic             push;

	logic             out_vld_q;
	logic [OUT_W-1:0] out_q;
	logic             skid_vld_q;
	logic [OUT_W-1:0] skid_q;

	// register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RST;
			sep_q   <= SEP_RST;
			lam_q   <= LAM_RST;
			mode_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_WIDTH:  width_q <= pwdata[WID_W-1:0];
				REG_SEP:    sep_q   <= pwdata[SEP_W-1:0];
				REG_LAMBDA: lam_q   <= pwdata[LAM_W-1:0];
				REG_MODE:   mode_q  <= pwdata[0];
				default:    mode_q  <= mode_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_SEP:    prdata = DATA_W'(sep_q);
			REG_LAMBDA: prdata = DATA_W'(lam_q);
			REG_MODE:   prdata = DATA_W'(mode_q);
			default:    prdata = '0;
		endcase
	end

	// input stage and valid line
	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1 <= screen_pos;
		end
	end

	// detector mode shifts the lanes by -d/2 and +d/2
	always_comb begin
		ys      = YL_W'(y_s1);
		hs      = signed'(YL_W'({sep_q, 3'b000}));
		ya      = mode_q ? (ys - hs) : ys;
		yb      = mode_q ? (ys + hs) : ys;
		lam_eff = (lam_q == '0) ? LAM_W'(1) : lam_q;
		cfg_a   = '{len: LEN_W'(width_q), lam: lam_eff, is_sinc: 1'b1};
		cfg_b   = '{len: (mode_q ? LEN_W'(width_q) : sep_q), lam: lam_eff,
			is_sinc: mode_q};
	end

	dsi_lane u_lane_a (
		.clk (clk),
		.en  (en),
		.y   (ya),
		.cfg (cfg_a),
		.env (env_a)
	);

	dsi_lane u_lane_b (
		.clk (clk),
		.en  (en),
		.y   (yb),
		.cfg (cfg_b),
		.env (env_b)
	);

	assign env_sum = {1'b0, env_a} + {1'b0, env_b};

	always_ff @(posedge clk) begin
		if (en) begin
			val_s2 <= mode_q ? env_sum[Q30_W:1] : q30_mul(env_a, env_b);
		end
	end

	always_comb begin
		rnd = val_s2 + RND_HALF;
		res = (rnd[Q30_W-1:14] > OUT_MAX) ? OUT_MAX : rnd[Q30_W-1:14];
	end

	assign push = en && vld_q[PIPE_LAT-1];

	// output register plus skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign intensity = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid slot full while output register empty");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_q <= OUT_MAX))
		else $error("intensity beat above full scale");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_ready && vld_q[PIPE_LAT-1]))
		else $error("skid slot filled without a stalled output beat");

endmodule
